### rtl/core/hmro_pkg.sv
// Package for the magnetic hydrogen RK4 oscillator: widths, constants, codes, helpers.
// No dependencies.
`timescale 1ns / 1ps
package hmro_pkg;

    localparam int FRACTION_BITS = 24;
    localparam int VAL_W = 32;
    localparam int FIELD_W = 27;
    localparam int PROD_W = 28;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] THRESH =
        32'(((64'd1 << FRACTION_BITS) + 64'd50000) / 64'd100000);
    localparam logic signed [31:0] TWO = 32'(64'd2 << FRACTION_BITS);

    localparam logic [2:0] REG_ENERGY = 3'd0;
    localparam logic [2:0] REG_TIME_STEP = 3'd1;
    localparam logic [2:0] REG_REG_TIME = 3'd2;
    localparam logic [2:0] REG_INIT_MU = 3'd3;
    localparam logic [2:0] REG_INIT_MUV = 3'd4;
    localparam logic [2:0] REG_INIT_NU = 3'd5;
    localparam logic [2:0] REG_INIT_NUV = 3'd6;

    // ALU operations
    localparam logic [1:0] OP_MUL = 2'd0;   // round(a*b >> F), sat32
    localparam logic [1:0] OP_ADD = 2'd1;   // sat32(a + b)
    localparam logic [1:0] OP_SUB = 2'd2;   // sat32(a - b)

    typedef struct packed {
        logic [1:0] op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_req_t;

    function automatic logic signed [31:0] sat64_32(input logic signed [63:0] v);
        if (v > 64'(S32_MAX)) return S32_MAX;
        if (v < 64'(S32_MIN)) return S32_MIN;
        return v[31:0];
    endfunction

    // floor((v + 2^(s-1)) / 2^s) == arithmetic shift of biased value
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int s);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic logic signed [26:0] sat27(input logic signed [31:0] v);
        if (v > 32'sd67108863) return 27'sh3FF_FFFF;
        if (v < -32'sd67108864) return 27'sh400_0000;
        return v[26:0];
    endfunction

    function automatic logic signed [27:0] sat28(input logic signed [31:0] v);
        if (v > 32'sd134217727) return 28'sh7FF_FFFF;
        if (v < -32'sd134217728) return 28'sh800_0000;
        return v[27:0];
    endfunction

endpackage

### rtl/core/hmro_if.sv
// Valid/ready stream channel interface.
// Depends on nothing; payload width set per instance.
`timescale 1ns / 1ps
interface hmro_if #(parameter int W = 1) (input logic clk);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/hmro_alu.sv
// Shared arithmetic unit: rounded fixed-point multiply or saturating add/sub.
// Depends on hmro_pkg. One result per cycle, registered.
`timescale 1ns / 1ps
module hmro_alu import hmro_pkg::*; (
    input  logic clk,
    input  alu_req_t req,
    output logic signed [31:0] res
);
    logic signed [63:0] prod;
    logic signed [31:0] res_next;
    logic signed [31:0] res_reg;

    always_comb
    begin
        prod = 64'(req.a) * 64'(req.b);
        unique case (req.op)
            OP_MUL: res_next = sat64_32(rnd_shr(prod, FRACTION_BITS));
            OP_ADD: res_next = sat64_32(64'(req.a) + 64'(req.b));
            OP_SUB: res_next = sat64_32(64'(req.a) - 64'(req.b));
            default: res_next = req.a;
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;
endmodule

### rtl/core/hmro_div.sv
// Radial unit: integer square root and restoring division, one bit per cycle.
// Depends on hmro_pkg. Computes h = min(S32_MAX, floor((dt<<F) / (2*isqrt(sq)))).
`timescale 1ns / 1ps
module hmro_div import hmro_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [63:0] sq,
    input  logic [30:0] dt,
    output logic done,
    output logic zero,
    output logic signed [31:0] h
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SQRT = 2'd1;
    localparam logic [1:0] S_DIV = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;
    localparam int NUM_W = 31 + FRACTION_BITS;

    logic [1:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] root_reg, root_next;
    logic [63:0] bit_reg, bit_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [63:0] q_reg, q_next;
    logic [64:0] drem_reg, drem_next;
    logic [64:0] trial;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        bit_next = bit_reg;
        num_next = num_reg;
        q_next = q_reg;
        drem_next = drem_reg;
        trial = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rem_next = sq;
                    root_next = '0;
                    bit_next = 64'd1 << 62;
                    num_next = NUM_W'(dt) << FRACTION_BITS;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    q_next = '0;
                    drem_next = '0;
                    cnt_next = 6'(NUM_W - 1);
                    state_next = (root_reg == '0) ? S_DONE : S_DIV;
                end
                else
                begin
                    if (rem_reg >= root_reg + bit_reg)
                    begin
                        rem_next = rem_reg - (root_reg + bit_reg);
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            S_DIV:
            begin
                trial = {drem_reg[63:0], num_reg[cnt_reg]};
                if (trial >= {root_reg, 1'b0})
                begin
                    drem_next = trial - {root_reg, 1'b0};
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    drem_next = trial;
                    q_next = {q_reg[62:0], 1'b0};
                end
                if (cnt_reg == '0)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        bit_reg <= bit_next;
        num_reg <= num_next;
        q_reg <= q_next;
        drem_reg <= drem_next;
    end

    assign done = (state_reg == S_DONE);
    assign zero = (root_reg == '0);
    assign h = (q_reg > 64'(S32_MAX)) ? S32_MAX : q_reg[31:0];
endmodule

### rtl/core/hmro_seq.sv
// Step sequencer: walks the RK4 stages through the shared ALU, at most one operation a cycle.
// Depends on hmro_pkg, hmro_alu, hmro_div.
`timescale 1ns / 1ps
module hmro_seq import hmro_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic restart,
    input  logic signed [31:0] energy,
    input  logic [30:0] time_step,
    input  logic regularized_time,
    input  logic signed [26:0] init_val [4],
    output logic busy,
    output logic done,
    output logic signed [31:0] x_out [4],
    output logic signed [31:0] prod_out,
    output logic signed [31:0] half_out,
    output logic unstable_out
);
    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ = 4'd1;
    localparam logic [3:0] S_RAD = 4'd2;
    localparam logic [3:0] S_ACC = 4'd3;
    localparam logic [3:0] S_KMUL = 4'd4;
    localparam logic [3:0] S_TMP = 4'd5;
    localparam logic [3:0] S_COMB = 4'd6;
    localparam logic [3:0] S_OUT = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] st_reg, st_next;
    logic [3:0] ph_reg, ph_next;     // micro step inside a state
    logic [1:0] stg_reg, stg_next;   // RK4 stage
    logic [1:0] var_reg, var_next;   // variable index
    logic signed [31:0] x_reg [4];
    logic signed [31:0] tmp_reg [4];
    logic signed [31:0] d_reg [4];
    logic signed [34:0] ksum_reg [4];
    logic signed [31:0] t0_reg, t1_reg, t2_reg;
    logic signed [31:0] h_reg;
    logic unst_reg;
    logic signed [31:0] p_reg, hd_reg;
    logic [63:0] sqa_reg;

    alu_req_t req;
    logic signed [31:0] r;
    logic div_start, div_done, div_zero;
    logic signed [31:0] div_h;

    hmro_alu u_alu (.clk(clk), .req(req), .res(r));
    hmro_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .sq(sqa_reg),
        .dt(time_step), .done(div_done), .zero(div_zero), .h(div_h));

    // acceleration operand: a = coordinate var, b = other coordinate
    logic [1:0] ai, bi;
    logic signed [31:0] acc_a, acc_b;
    logic signed [63:0] km;
    logic signed [34:0] ks, kq, kv_full;
    logic signed [31:0] kv;
    logic [33:0] kn;
    logic [15:0] khi;
    logic [18:0] klo;
    logic [39:0] kr;

    always_comb
    begin
        ai = (var_reg == 2'd1) ? 2'd0 : 2'd2;
        bi = (var_reg == 2'd1) ? 2'd2 : 2'd0;
        acc_a = tmp_reg[ai];
        acc_b = tmp_reg[bi];
        // the divide by 6 of the RK4 sum, rounding away from zero on ties
        ks = ksum_reg[var_reg];
        km = (ks[34] ? -64'(ks) : 64'(ks)) + 64'sd3;
        // halve, then split at 2^18 (1 mod 3) and divide the small part by 3
        // with a reciprocal multiply
        kn = km[34:1];
        khi = kn[33:18];
        klo = 19'(kn[17:0]) + 19'(khi);
        kr = 40'(klo) * 40'd699051;
        kq = 35'(khi) * 35'd87381 + 35'(kr[39:21]);
        kv_full = ks[34] ? -kq : kq;
        kv = kv_full[31:0];
    end

    always_comb
    begin
        req.op = OP_MUL;
        req.a = '0;
        req.b = '0;
        unique case (st_reg)
            S_ACC:
            begin
                // ph: 0 aa,1 bb,2 2aa,3 inner,4 a*bb,5 *inner,6 E*a,7 Ea-t/4,8 +Ea,9 store
                unique case (ph_reg)
                    4'd0: begin req.a = acc_a; req.b = acc_a; end
                    4'd1: begin req.a = acc_b; req.b = acc_b; end
                    4'd2: begin req.op = OP_ADD; req.a = t0_reg; req.b = t0_reg; end
                    4'd3: begin req.op = OP_ADD; req.a = r; req.b = t1_reg; end
                    4'd4: begin req.a = acc_a; req.b = t1_reg; end
                    4'd5: begin req.a = r; req.b = t2_reg; end
                    4'd6: begin req.a = energy; req.b = acc_a; end
                    4'd7: begin req.op = OP_SUB; req.a = r; req.b = t0_reg; end
                    default: begin req.op = OP_ADD; req.a = t1_reg; req.b = r; end
                endcase
            end
            S_KMUL: begin req.a = h_reg; req.b = d_reg[var_reg]; end
            S_TMP:
            begin
                req.op = OP_ADD;
                req.a = x_reg[var_reg];
                req.b = (stg_reg[1]) ? t0_reg : 32'(rnd_shr(64'(t0_reg), 1));
            end
            S_COMB: begin req.op = OP_ADD; req.a = x_reg[var_reg]; req.b = kv; end
            S_OUT:
            begin
                unique case (ph_reg)
                    4'd0: begin req.a = x_reg[0]; req.b = x_reg[2]; end
                    4'd1: begin req.a = x_reg[0]; req.b = x_reg[0]; end
                    4'd2: begin req.a = x_reg[2]; req.b = x_reg[2]; end
                    default: begin req.op = OP_SUB; req.a = t1_reg; req.b = r; end
                endcase
            end
            default: ;
        endcase
    end

    logic signed [31:0] flushed;
    always_comb
    begin
        flushed = r;
        if (r < THRESH && r > -THRESH)
            flushed = '0;
    end

    always_comb
    begin
        st_next = st_reg;
        ph_next = ph_reg;
        stg_next = stg_reg;
        var_next = var_reg;
        div_start = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    st_next = regularized_time ? S_ACC : S_SQ;
                    ph_next = '0;
                    stg_next = '0;
                    var_next = 2'd1;
                end
            end
            S_SQ: st_next = S_RAD;
            S_RAD:
            begin
                div_start = (ph_reg == 4'd0);
                ph_next = 4'd1;
                if (div_done)
                begin
                    ph_next = '0;
                    st_next = div_zero ? S_OUT : S_ACC;
                end
            end
            S_ACC:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd9)
                begin
                    ph_next = '0;
                    if (var_reg == 2'd1)
                        var_next = 2'd3;
                    else
                    begin
                        var_next = 2'd0;
                        st_next = S_KMUL;
                    end
                end
            end
            S_KMUL:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd1)
                begin
                    ph_next = '0;
                    st_next = S_TMP;
                end
            end
            S_TMP:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd1)
                begin
                    ph_next = '0;
                    if (var_reg != 2'd3)
                    begin
                        var_next = var_reg + 2'd1;
                        st_next = S_KMUL;
                    end
                    else if (stg_reg != 2'd3)
                    begin
                        stg_next = stg_reg + 2'd1;
                        var_next = 2'd1;
                        st_next = S_ACC;
                    end
                    else
                    begin
                        var_next = 2'd0;
                        st_next = S_COMB;
                    end
                end
            end
            S_COMB:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd1)
                begin
                    ph_next = '0;
                    var_next = var_reg + 2'd1;
                    if (var_reg == 2'd3)
                        st_next = S_OUT;
                end
            end
            S_OUT:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd4)
                begin
                    ph_next = '0;
                    st_next = S_DONE;
                end
            end
            S_DONE: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ph_reg <= '0;
            stg_reg <= '0;
            var_reg <= '0;
            for (int i = 0; i < 4; i++)
                x_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            ph_reg <= ph_next;
            stg_reg <= stg_next;
            var_reg <= var_next;
            if (st_reg == S_IDLE && start && restart)
                for (int i = 0; i < 4; i++)
                    x_reg[i] <= 32'(init_val[i]);
            if (st_reg == S_COMB && ph_reg == 4'd1)
            begin
                x_reg[var_reg] <= flushed;
                if (flushed > TWO)
                    x_reg[var_reg] <= TWO;
                if (flushed < -TWO)
                    x_reg[var_reg] <= -TWO;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                unst_reg <= 1'b0;
                h_reg <= 32'(time_step);
                for (int i = 0; i < 4; i++)
                begin
                    tmp_reg[i] <= (start && restart) ? 32'(init_val[i]) : x_reg[i];
                    ksum_reg[i] <= '0;
                end
            end
            S_SQ:
            begin
                sqa_reg <= 64'(64'(x_reg[0]) * 64'(x_reg[0]))
                         + 64'(64'(x_reg[2]) * 64'(x_reg[2]));
            end
            S_RAD:
            begin
                if (div_done)
                begin
                    h_reg <= div_h;
                    unst_reg <= div_zero;
                end
            end
            S_ACC:
            begin
                unique case (ph_reg)
                    4'd1: t0_reg <= r;
                    4'd2: t1_reg <= r;
                    4'd4: t2_reg <= r;
                    4'd6: t0_reg <= 32'(rnd_shr(64'(r), 2));
                    4'd7: t1_reg <= r;
                    4'd9: d_reg[var_reg] <= r;
                    default: ;
                endcase
                if (var_reg == 2'd1 && ph_reg == 4'd0)
                begin
                    d_reg[0] <= tmp_reg[1];
                    d_reg[2] <= tmp_reg[3];
                end
            end
            S_KMUL:
            begin
                if (ph_reg == 4'd1)
                begin
                    t0_reg <= r;
                    ksum_reg[var_reg] <= ksum_reg[var_reg]
                        + ((stg_reg == 2'd1 || stg_reg == 2'd2) ? 35'(r) <<< 1 : 35'(r));
                end
            end
            S_TMP:
            begin
                if (ph_reg == 4'd1)
                    tmp_reg[var_reg] <= r;
            end
            S_COMB:
            begin
                if (ph_reg == 4'd1 && (flushed > TWO || flushed < -TWO))
                    unst_reg <= 1'b1;
            end
            S_OUT:
            begin
                unique case (ph_reg)
                    4'd1: p_reg <= r;
                    4'd2: t1_reg <= r;
                    4'd4: hd_reg <= 32'(rnd_shr(64'(r), 1));
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign busy = (st_reg != S_IDLE);
    assign done = (st_reg == S_DONE);
    assign x_out = x_reg;
    assign prod_out = p_reg;
    assign half_out = hd_reg;
    assign unstable_out = unst_reg;
endmodule

### rtl/core/hydrogen_magnetic_rk4_oscillator.sv
// Top level of the magnetic hydrogen RK4 oscillator: APB registers, channels, result register.
// Depends on hmro_pkg, hmro_if, hmro_seq.
`timescale 1ns / 1ps
// One input beat advances the oscillator by one RK4 step through a single shared
// multiply/add unit under a sequencer. With regularized time the step runs 4 stages,
// then combines the stage sums, forms the products and finishes; scaling the step by
// radius adds the square and the bit-serial square-root and division unit, and a zero
// radius skips the stages and goes straight to the products. in.ready is low while a
// step runs or a result beat waits in the output register, so a new input beat is
// taken only after the last result beat has left.
module hydrogen_magnetic_rk4_oscillator import hmro_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    hmro_if.sink in,
    hmro_if.source out,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [4:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    logic signed [31:0] energy_reg;
    logic [30:0] time_step_reg;
    logic reg_time_reg;
    logic signed [26:0] init_reg [4];
    logic out_valid_reg;
    logic [163:0] out_data_reg;
    logic busy, done, unst;
    logic signed [31:0] xo [4];
    logic signed [31:0] po, ho;
    logic start;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    assign in.ready = !busy && !out_valid_reg;
    assign start = in.valid && in.ready;

    hmro_seq u_seq (.clk(clk), .rst_n(rst_n), .start(start), .restart(in.data[0]),
        .energy(energy_reg), .time_step(time_step_reg), .regularized_time(reg_time_reg),
        .init_val(init_reg), .busy(busy), .done(done), .x_out(xo), .prod_out(po),
        .half_out(ho), .unstable_out(unst));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= -32'sd8388608;
            time_step_reg <= 31'd167772;
            reg_time_reg <= 1'b1;
            for (int i = 0; i < 4; i++)
                init_reg[i] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (ridx)
                    REG_ENERGY: energy_reg <= pwdata;
                    REG_TIME_STEP: time_step_reg <= pwdata[30:0];
                    REG_REG_TIME: reg_time_reg <= pwdata[0];
                    REG_INIT_MU: init_reg[0] <= pwdata[26:0];
                    REG_INIT_MUV: init_reg[1] <= pwdata[26:0];
                    REG_INIT_NU: init_reg[2] <= pwdata[26:0];
                    REG_INIT_NUV: init_reg[3] <= pwdata[26:0];
                    default: ;
                endcase
            end
            if (done)
                out_valid_reg <= 1'b1;
            else if (out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_data_reg <= {unst, sat27(ho), sat28(po), sat27(xo[3]), sat27(xo[2]),
                             sat27(xo[1]), sat27(xo[0])};
    end

    always_comb
    begin
        unique case (ridx)
            REG_ENERGY: prdata = energy_reg;
            REG_TIME_STEP: prdata = {1'b0, time_step_reg};
            REG_REG_TIME: prdata = {31'd0, reg_time_reg};
            REG_INIT_MU: prdata = 32'(init_reg[0]);
            REG_INIT_MUV: prdata = 32'(init_reg[1]);
            REG_INIT_NU: prdata = 32'(init_reg[2]);
            REG_INIT_NUV: prdata = 32'(init_reg[3]);
            default: prdata = '0;
        endcase
    end

    assign out.valid = out_valid_reg;
    assign out.data = out_data_reg;
endmodule

### rtl/core/hmro_checker.sv
// Port-level checker for the oscillator, bound to the top level.
// Depends on hmro_pkg.
`timescale 1ns / 1ps
module hmro_checker import hmro_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [163:0] out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while step in progress");
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result appeared without a step");
endmodule

bind hydrogen_magnetic_rk4_oscillator hmro_checker u_chk (.clk(clk), .rst_n(rst_n),
    .in_valid(in.valid), .in_ready(in.ready), .out_valid(out.valid),
    .out_ready(out.ready), .out_data(out.data));
